// ===== rtl/core/rlfe_pkg.sv =====
// Shared types, constants and helpers for the run-length frame encoder.
package rlfe_pkg;

  // Default run counter width; runs are further capped by the 16-bit record field
  localparam int unsigned RunCountBitsDefault = 16;
  localparam int unsigned RecLenBits          = 16;
  localparam int unsigned CmdDepthDefault     = 4;

  // Record framing bytes
  localparam logic [7:0] RecMark0 = 8'hFD;
  localparam logic [7:0] RecMark1 = 8'hFC;
  localparam logic [7:0] RecEnd   = 8'hFB;
  // Trailer starts at 'a' and counts up to 'd'
  localparam logic [7:0] TrailBase = 8'h61;

  // Byte sequencer positions within one item's output
  localparam logic [4:0] StepRecBase   = 5'd0;
  localparam logic [4:0] StepRecLast   = 5'd5;
  localparam logic [4:0] StepFlushBase = 5'd6;
  localparam logic [4:0] StepTotalBase = 5'd12;
  localparam logic [4:0] StepTrailBase = 5'd16;
  localparam logic [4:0] StepLast      = 5'd19;

  // Record offsets
  localparam logic [2:0] OffMark0 = 3'd0;
  localparam logic [2:0] OffMark1 = 3'd1;
  localparam logic [2:0] OffValue = 3'd2;
  localparam logic [2:0] OffLenLo = 3'd3;
  localparam logic [2:0] OffLenHi = 3'd4;
  localparam logic [2:0] OffEnd   = 3'd5;

  // Work for the back end, one entry per pixel that produces output
  typedef struct packed {
    logic                  rec;      // a finished run record comes first
    logic [7:0]            rec_val;
    logic [RecLenBits-1:0] rec_len;
    logic                  fin;      // flush record, total and trailer follow
    logic [7:0]            fin_val;
    logic [RecLenBits-1:0] fin_len;
    logic [31:0]           total;
  } rlfe_cmd_t;

  // One byte of a six-byte run record
  function automatic logic [7:0] rec_byte(input logic [2:0] off, input logic [7:0] val,
                                          input logic [RecLenBits-1:0] len);
    logic [7:0] b;
    begin
      case (off)
        OffMark0: b = RecMark0;
        OffMark1: b = RecMark1;
        OffValue: b = val;
        OffLenLo: b = len[7:0];
        OffLenHi: b = len[15:8];
        OffEnd:   b = RecEnd;
        default:  b = RecEnd;
      endcase
      return b;
    end
  endfunction

endpackage

// ===== rtl/core/rlfe_front.sv =====
// Front end: tracks the open run and turns each pixel into back-end work.
module rlfe_front
  import rlfe_pkg::*;
#(
  parameter int unsigned RunCountBits = RunCountBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] pixel_i,
  input  logic       final_pixel_i,
  output logic       cmd_push_o,
  output rlfe_cmd_t  cmd_o
);

  localparam int unsigned LenW = (RunCountBits >= RecLenBits) ? RecLenBits : RunCountBits;

  logic [7:0]      cur_q, cur_d;
  logic [LenW-1:0] len_q, len_d;
  logic [31:0]     runs_q, runs_d;
  logic            rec;
  logic [7:0]      run_val;
  logic [LenW-1:0] run_len;

  // Run tracking for the current pixel
  always_comb begin
    rec     = 1'b0;
    run_val = pixel_i;
    run_len = LenW'(1);
    if (len_q != '0 && pixel_i == cur_q && len_q != '1) begin
      run_val = cur_q;
      run_len = len_q + LenW'(1);
    end else if (len_q != '0) begin
      rec = 1'b1;
    end
  end

  // Next state; the final pixel returns everything to reset values
  always_comb begin
    cur_d  = cur_q;
    len_d  = len_q;
    runs_d = runs_q;
    if (accept_i) begin
      if (final_pixel_i) begin
        cur_d  = '0;
        len_d  = '0;
        runs_d = '0;
      end else begin
        cur_d  = run_val;
        len_d  = run_len;
        runs_d = runs_q + 32'(rec);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      len_q  <= '0;
      runs_q <= '0;
    end else begin
      cur_q  <= cur_d;
      len_q  <= len_d;
      runs_q <= runs_d;
    end
  end

  // Work entry for the back end
  always_comb begin
    cmd_o.rec     = rec;
    cmd_o.rec_val = cur_q;
    cmd_o.rec_len = RecLenBits'(len_q);
    cmd_o.fin     = final_pixel_i;
    cmd_o.fin_val = run_val;
    cmd_o.fin_len = RecLenBits'(run_len);
    cmd_o.total   = runs_q + 32'(rec) + 32'd1;
    cmd_push_o    = accept_i && (rec || final_pixel_i);
  end

endmodule

// ===== rtl/core/rlfe_cmd_fifo.sv =====
// Short queue of work entries between front and back end.
module rlfe_cmd_fifo
  import rlfe_pkg::*;
#(
  parameter int unsigned Depth = CmdDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  rlfe_cmd_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output rlfe_cmd_t data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  rlfe_cmd_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill update
  always_comb begin
    wr_d  = do_push ? ((wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1)) : wr_q;
    rd_d  = do_pop  ? ((rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1)) : rd_q;
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("fifo fill count beyond depth");
  a_fill_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("fifo fill count missed a push");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CntW'(Depth)) |-> wr_q == rd_q)
    else $error("fifo pointers disagree with fill count");
`endif

endmodule

// ===== rtl/core/rlfe_back.sv =====
// Back end: serializes each work entry into bytes through an output register.
module rlfe_back
  import rlfe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  rlfe_cmd_t cmd_i,
  output logic      cmd_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output logic [7:0] out_byte_o,
  output logic      last_of_item_o
);

  logic [4:0] step_q, step_d, cur_step, rel;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       load, step_last;

  assign empty_o        = !out_valid_q;
  assign out_byte_o     = byte_q;
  assign last_of_item_o = last_q;

  // Output register can take a byte when empty or being drained
  assign load      = cmd_valid_i && (!out_valid_q || pop_i);
  assign cur_step  = (step_q == StepRecBase && !cmd_i.rec) ? StepFlushBase : step_q;
  assign step_last = (cur_step == StepLast) || (cur_step == StepRecLast && !cmd_i.fin);
  assign cmd_pop_o = load && step_last;

  // Byte selection for the current step
  always_comb begin
    rel    = '0;
    byte_d = '0;
    if (cur_step < StepFlushBase) begin
      rel    = cur_step - StepRecBase;
      byte_d = rec_byte(rel[2:0], cmd_i.rec_val, cmd_i.rec_len);
    end else if (cur_step < StepTotalBase) begin
      rel    = cur_step - StepFlushBase;
      byte_d = rec_byte(rel[2:0], cmd_i.fin_val, cmd_i.fin_len);
    end else if (cur_step < StepTrailBase) begin
      rel    = cur_step - StepTotalBase;
      byte_d = 8'(cmd_i.total >> {~rel[1:0], 3'b000});
    end else begin
      rel    = cur_step - StepTrailBase;
      byte_d = TrailBase + {6'd0, rel[1:0]};
    end
    last_d = step_last;
  end

  // Sequencer and output valid
  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (load) begin
      step_d      = step_last ? StepRecBase : cur_step + 5'd1;
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StepRecBase;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

`ifndef SYNTH
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= StepLast) else $error("byte step out of range");
  a_step_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> step_q == StepRecBase) else $error("step not rewound after entry");
  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_valid_i |-> step_q == StepRecBase) else $error("step moved without an entry");
  a_last_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && last_d |-> cmd_pop_o) else $error("last byte without releasing entry");
`endif

endmodule

// ===== rtl/core/run_length_frame_encoder_core.sv =====
// Run-length frame encoder: top level joining front end, work queue and back end.
// A pixel with output is queued first; its first byte then loads into the output register.
// Throughput: one pixel per cycle while the work queue has room; bytes leave at one per cycle
// while pop is held; an entry leaves the queue with its last byte; queue depth absorbs bursts.
// Reset (rst_ni, asynchronous, active low) clears the open run, run count, queue and output.
module run_length_frame_encoder_core
  import rlfe_pkg::*;
#(
  parameter int unsigned RunCountBits = RunCountBitsDefault,
  parameter int unsigned CmdDepth     = CmdDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] pixel_i,
  input  logic       final_pixel_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_of_item_o
);

  logic      accept;
  logic      cmd_push, cmd_pop, cmd_valid;
  rlfe_cmd_t cmd_in, cmd_head;

  assign accept = push && !full;

  rlfe_front #(
    .RunCountBits(RunCountBits)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .pixel_i      (pixel_i),
    .final_pixel_i(final_pixel_i),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  rlfe_cmd_fifo #(
    .Depth(CmdDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .full_o (full),
    .pop_i  (cmd_pop),
    .valid_o(cmd_valid),
    .data_o (cmd_head)
  );

  rlfe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd_head),
    .cmd_pop_o     (cmd_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .out_byte_o    (out_byte_o),
    .last_of_item_o(last_of_item_o)
  );

endmodule
